[hdl/cfdf_pkg.sv]
// Shared types and constants for the control frame deframer with byte queue.
// Used by every module of the block but cfdf_ram; no dependencies.
`timescale 1ns / 1ps

package cfdf_pkg;

  // Sizing of the queue and of the received frames
  localparam int unsigned QUEUE_DEPTH  = 256;
  localparam int unsigned FRAME_LEN    = 64;
  localparam int unsigned PAYLOAD_MAX  = 60;
  localparam int unsigned HEADER_BYTES = 4;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned POS_W  = $clog2(FRAME_LEN + 1);
  localparam int unsigned CMP_W  = (POS_W > BYTE_W) ? POS_W : BYTE_W;

  // Stream payload layout
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_FIELD_W = BYTE_W + FILL_W + 3 * CNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Transaction kinds carried in tuser bit 0
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
  } magic_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } push_t;

  typedef struct packed {
    logic              pop_valid;
    logic [FILL_W-1:0] fill;
    logic [CNT_W-1:0]  accepted;
    logic [CNT_W-1:0]  dropped;
  } qstat_t;

endpackage

[hdl/control_frame_deframer_fifo.sv]
// Path: an accepted transaction is registered in the result stage, then in the output register.
// Throughput: one transaction per cycle, frame byte or pop alike, unless the output stalls;
// a single-port-pair RAM holds the queue and one result stage plus one output register
// follow it. Reset: asynchronous, active low; clears position, header state, indexes,
// fill level, counters and magic registers. Queue RAM contents are not cleared.
`timescale 1ns / 1ps

module control_frame_deframer_fifo (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write port
  input  logic                                  cfg_we_i,
  input  logic [cfdf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [cfdf_pkg::BYTE_W-1:0]           cfg_wdata_i,
  // Input stream
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [cfdf_pkg::BYTE_W-1:0]           s_axis_tdata_i,  // rx_byte
  input  logic [cfdf_pkg::IN_TUSER_W-1:0]       s_axis_tuser_i,  // op, frame_start
  // Output stream
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // popped_byte, queue_fill, frames_accepted, bytes_accepted, bytes_dropped, zero pad
  output logic [cfdf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                                  m_axis_tuser_o   // pop_valid
);

  cfdf_pkg::magic_t            magic_q, magic_d;
  cfdf_pkg::push_t             push;
  cfdf_pkg::qstat_t            qstat, st1_stat_q;
  logic [cfdf_pkg::CNT_W-1:0]  frames, st1_frames_q;
  logic [cfdf_pkg::BYTE_W-1:0] rd_data, popped;
  logic                        s_fire, byte_en, pop_en;
  logic                        st1_valid_q, st1_valid_d, st1_move;
  logic                        out_valid_q, out_valid_d;
  logic [cfdf_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic                        out_pop_q;

  // Write configuration registers
  always_comb begin
    magic_d = magic_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        cfdf_pkg::REG_MAGIC_FIRST:  magic_d.first  = cfg_wdata_i;
        cfdf_pkg::REG_MAGIC_SECOND: magic_d.second = cfg_wdata_i;
        default:                    magic_d        = magic_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0;
    end else begin
      magic_q <= magic_d;
    end
  end

  // Accept a transaction whenever the result stage is empty or can empty
  assign st1_move        = st1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !st1_valid_q || st1_move;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign byte_en         = s_fire && (s_axis_tuser_i[0] == cfdf_pkg::OP_BYTE);
  assign pop_en          = s_fire && (s_axis_tuser_i[0] == cfdf_pkg::OP_POP);

  cfdf_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (byte_en),
    .start_i   (s_axis_tuser_i[1]),
    .rx_byte_i (s_axis_tdata_i),
    .magic_i   (magic_q),
    .push_o    (push),
    .frames_o  (frames)
  );

  cfdf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pop_i     (pop_en),
    .stat_o    (qstat),
    .rd_data_o (rd_data)
  );

  // Result stage: snapshot of the state after the step, RAM read in flight
  always_comb begin
    st1_valid_d = st1_valid_q;
    if (s_fire) begin
      st1_valid_d = 1'b1;
    end else if (st1_move) begin
      st1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_valid_q <= 1'b0;
    end else begin
      st1_valid_q <= st1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      st1_stat_q   <= qstat;
      st1_frames_q <= frames;
    end
  end

  // Output register: capture RAM data with the snapshot
  assign popped = st1_stat_q.pop_valid ? rd_data : '0;

  always_comb begin
    out_valid_d = out_valid_q;
    if (st1_move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st1_move) begin
      out_pop_q  <= st1_stat_q.pop_valid;
      out_data_q <= {{cfdf_pkg::OUT_PAD_W{1'b0}}, st1_stat_q.dropped, st1_stat_q.accepted,
                     st1_frames_q, st1_stat_q.fill, popped};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_pop_q;

endmodule

[hdl/cfdf_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cfdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/cfdf_parse.sv]
// Frame parser: tracks byte position, checks the header and counts control frames.
// Depends on cfdf_pkg.
`timescale 1ns / 1ps

module cfdf_parse (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          byte_en_i,
  input  logic                          start_i,
  input  logic [cfdf_pkg::BYTE_W-1:0]   rx_byte_i,
  input  cfdf_pkg::magic_t              magic_i,
  output cfdf_pkg::push_t               push_o,
  output logic [cfdf_pkg::CNT_W-1:0]    frames_o
);

  logic [cfdf_pkg::POS_W-1:0]  pos_q, pos_d, pos_eff;
  logic                        hdr_good_q, hdr_good_d;
  logic [cfdf_pkg::BYTE_W-1:0] len_q, len_d;
  logic [cfdf_pkg::CNT_W-1:0]  frames_q, frames_d;
  logic [cfdf_pkg::CMP_W-1:0]  payload_off;
  logic                        push;

  assign pos_eff     = start_i ? '0 : pos_q;
  assign payload_off = cfdf_pkg::CMP_W'(pos_eff) - cfdf_pkg::CMP_W'(cfdf_pkg::HEADER_BYTES);

  // Decode the byte at its frame position
  always_comb begin
    pos_d      = pos_q;
    hdr_good_d = hdr_good_q;
    len_d      = len_q;
    frames_d   = frames_q;
    push       = 1'b0;
    if (byte_en_i) begin
      pos_d = pos_eff;
      if (pos_eff < cfdf_pkg::POS_W'(cfdf_pkg::FRAME_LEN)) begin
        pos_d = pos_eff + 1'b1;
        if (pos_eff == cfdf_pkg::POS_W'(0)) begin
          hdr_good_d = (rx_byte_i == magic_i.first);
        end else if (pos_eff == cfdf_pkg::POS_W'(1)) begin
          hdr_good_d = hdr_good_q && (rx_byte_i == magic_i.second);
        end else if (pos_eff == cfdf_pkg::POS_W'(2)) begin
          if (hdr_good_q && (rx_byte_i <= cfdf_pkg::BYTE_W'(cfdf_pkg::PAYLOAD_MAX))) begin
            len_d    = rx_byte_i;
            frames_d = frames_q + 1'b1;
          end else begin
            hdr_good_d = 1'b0;
            len_d      = '0;
          end
        end else if (pos_eff >= cfdf_pkg::POS_W'(cfdf_pkg::HEADER_BYTES)) begin
          push = hdr_good_q && (payload_off < cfdf_pkg::CMP_W'(len_q));
        end
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hdr_good_q <= 1'b0;
      len_q      <= '0;
      frames_q   <= '0;
    end else begin
      pos_q      <= pos_d;
      hdr_good_q <= hdr_good_d;
      len_q      <= len_d;
      frames_q   <= frames_d;
    end
  end

  assign push_o.valid = push;
  assign push_o.data  = rx_byte_i;
  assign frames_o     = frames_d;

endmodule

[hdl/cfdf_queue.sv]
// Circular byte queue: indexes, fill level and push/drop counters around one RAM.
// Depends on cfdf_pkg and cfdf_ram.
`timescale 1ns / 1ps

module cfdf_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cfdf_pkg::push_t             push_i,
  input  logic                        pop_i,
  output cfdf_pkg::qstat_t            stat_o,
  output logic [cfdf_pkg::BYTE_W-1:0] rd_data_o
);

  logic [cfdf_pkg::QIDX_W-1:0] wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  logic [cfdf_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [cfdf_pkg::CNT_W-1:0]  acc_q, acc_d, drop_q, drop_d;
  logic                        full, empty, ram_we, ram_re;

  assign full   = (fill_q == cfdf_pkg::FILL_W'(cfdf_pkg::QUEUE_DEPTH));
  assign empty  = (fill_q == '0);
  assign ram_we = push_i.valid && !full;
  assign ram_re = pop_i && !empty;

  // Advance indexes, fill level and counters
  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    fill_d   = fill_q;
    acc_d    = acc_q;
    drop_d   = drop_q;
    if (ram_we) begin
      wr_idx_d = (wr_idx_q == cfdf_pkg::QIDX_W'(cfdf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_idx_q + 1'b1;
      fill_d   = fill_q + 1'b1;
      acc_d    = acc_q + 1'b1;
    end else if (push_i.valid) begin
      drop_d = drop_q + 1'b1;
    end
    if (ram_re) begin
      rd_idx_d = (rd_idx_q == cfdf_pkg::QIDX_W'(cfdf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_idx_q + 1'b1;
      fill_d   = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      fill_q   <= '0;
      acc_q    <= '0;
      drop_q   <= '0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      fill_q   <= fill_d;
      acc_q    <= acc_d;
      drop_q   <= drop_d;
    end
  end

  // Queue storage; a pop never reads the entry written in the same cycle
  cfdf_ram #(
    .WIDTH (cfdf_pkg::BYTE_W),
    .DEPTH (cfdf_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (push_i.data),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_data_o)
  );

  assign stat_o.pop_valid = ram_re;
  assign stat_o.fill      = fill_d;
  assign stat_o.accepted  = acc_d;
  assign stat_o.dropped   = drop_d;

  // Fill never exceeds the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cfdf_pkg::FILL_W'(cfdf_pkg::QUEUE_DEPTH))
    else $error("queue fill level above depth");

  // Push and pop never hit the RAM in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("queue write and read in the same cycle");

  // An empty queue has matching indexes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> (wr_idx_q == rd_idx_q))
    else $error("empty queue with unequal indexes");

  // A taken push raises the fill level by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (fill_q == $past(fill_q) + 1'b1))
    else $error("fill level did not follow a push");

endmodule
